// ===== hw/rtl/hsc16_pkg.sv =====
// ----------------------------------------------------------------------------
// hsc16_pkg: shared types and constants for the header sync CRC-16 deframer
// Header length, frame length limits, register indexes and the byte-wide
// CRC-16/Modbus update.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc16_pkg;

   localparam int HDR_LEN       = 6;
   localparam int MAX_FRAME_LEN = 128;
   localparam int MIN_FRAME_LEN = HDR_LEN + 3;
   localparam int BYTE_W        = 8;
   localparam int POS_W         = 7;
   localparam int LEN_W         = 8;
   localparam int MATCH_W       = $clog2(HDR_LEN + 1);
   localparam int CRC_W         = 16;
   localparam int CSR_IDX_W     = 3;

   localparam logic [CRC_W-1:0] CRC_POLY      = 16'hA001;
   localparam logic [CRC_W-1:0] CRC_INIT      = 16'hFFFF;
   localparam logic [LEN_W-1:0] FRAME_LEN_RST = 8'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HDR0      = 3'd0,
      REG_HDR1      = 3'd1,
      REG_HDR2      = 3'd2,
      REG_HDR3      = 3'd3,
      REG_HDR4      = 3'd4,
      REG_HDR5      = 3'd5,
      REG_FRAME_LEN = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [HDR_LEN-1:0][BYTE_W-1:0] header;
      logic [LEN_W-1:0]               frame_len;
   } cfg_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hsc16_csr.sv =====
// ----------------------------------------------------------------------------
// hsc16_csr: configuration registers
// Holds the six header bytes and the frame length; presents the frame length
// clamped to the supported range.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc16_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [hsc16_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hsc16_pkg::BYTE_W-1:0]     csr_wdata,
   output hsc16_pkg::cfg_type                    cfg
);

   hsc16_pkg::cfg_type cfg_ff;
   hsc16_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            hsc16_pkg::REG_HDR0, hsc16_pkg::REG_HDR1, hsc16_pkg::REG_HDR2,
            hsc16_pkg::REG_HDR3, hsc16_pkg::REG_HDR4, hsc16_pkg::REG_HDR5: begin
               cfg_in.header[csr_index] = csr_wdata;
            end
            hsc16_pkg::REG_FRAME_LEN: begin
               cfg_in.frame_len = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header    <= '0;
         cfg_ff.frame_len <= hsc16_pkg::FRAME_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // clamp length to the supported range
   always_comb begin
      cfg = cfg_ff;
      if (cfg_ff.frame_len < hsc16_pkg::LEN_W'(hsc16_pkg::MIN_FRAME_LEN)) begin
         cfg.frame_len = hsc16_pkg::LEN_W'(hsc16_pkg::MIN_FRAME_LEN);
      end else if (cfg_ff.frame_len > hsc16_pkg::LEN_W'(hsc16_pkg::MAX_FRAME_LEN)) begin
         cfg.frame_len = hsc16_pkg::LEN_W'(hsc16_pkg::MAX_FRAME_LEN);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/header_sync_crc16_deframer.sv =====
// ----------------------------------------------------------------------------
// header_sync_crc16_deframer: fixed-length frame sync with CRC-16/Modbus check
// Usage:
//   req_* carries received bytes, one item per byte. The block hunts for the
//   six configured header bytes, then passes each following frame byte out on
//   rsp_* with its frame position. rsp_tlast marks the final CRC byte and
//   rsp_tuser then says whether the received CRC (high byte first) matches
//   CRC-16/Modbus over all bytes before the two CRC bytes. Header bytes give
//   no item. After the last byte the hunt starts again.
//   csr_* writes the header bytes (index 0..5) and the frame length (index
//   6); write only while idle.
//   rsp_tvalid rises in the cycle after a frame byte is accepted; one byte is
//   taken every cycle unless rsp_* stalls, set by the byte-wide CRC and match logic.
//   A result register sits on rsp_*: while it holds an item the receiver has
//   not taken, req_tready drops and the byte stream waits.
//   Synchronous reset clears the hunt, the CRC to 0xFFFF, the header bytes
//   to zero and the frame length to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module header_sync_crc16_deframer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] rx_byte
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [15:0]                     rsp_tdata,   // [7:0] frame_byte,
                                                             // [14:8] byte_index
   output      logic                            rsp_tlast,   // last_of_frame
   output      logic                            rsp_tuser,   // crc_good
   input  wire logic                            csr_we,
   input  wire logic [hsc16_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hsc16_pkg::BYTE_W-1:0]    csr_wdata
);

   localparam logic [hsc16_pkg::MATCH_W-1:0] HDR_CNT =
      hsc16_pkg::MATCH_W'(hsc16_pkg::HDR_LEN);

   hsc16_pkg::cfg_type cfg;

   hsc16_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic [hsc16_pkg::MATCH_W-1:0] matched_ff, matched_in;
   logic [hsc16_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                          in_frame_ff, in_frame_in;
   logic [hsc16_pkg::CRC_W-1:0]   crc_ff, crc_in;
   logic [hsc16_pkg::BYTE_W-1:0]  crc_hi_ff, crc_hi_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hsc16_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic [hsc16_pkg::POS_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_good_ff, rsp_good_in;

   logic                          in_fire;
   logic                          frame_end;
   logic [hsc16_pkg::LEN_W-1:0]   pos_ext;
   logic [hsc16_pkg::BYTE_W-1:0]  b;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign in_fire    = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign pos_ext    = {1'b0, pos_ff};
   assign frame_end  = (pos_ext + 8'd1) >= cfg.frame_len;

   always_comb begin
      matched_in   = matched_ff;
      pos_in       = pos_ff;
      in_frame_in  = in_frame_ff;
      crc_in       = crc_ff;
      crc_hi_in    = crc_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_good_in  = rsp_good_ff;
      if (in_fire) begin
         if (!in_frame_ff) begin
            if (matched_ff < HDR_CNT && b == cfg.header[matched_ff]) begin
               crc_in     = hsc16_pkg::crc_byte(crc_ff, b);
               matched_in = matched_ff + 1'b1;
            end else if (b == cfg.header[0]) begin
               crc_in     = hsc16_pkg::crc_byte(hsc16_pkg::CRC_INIT, b);
               matched_in = hsc16_pkg::MATCH_W'(1);
            end else begin
               crc_in     = hsc16_pkg::CRC_INIT;
               matched_in = '0;
            end
            if (matched_in == HDR_CNT) begin
               in_frame_in = 1'b1;
               pos_in      = hsc16_pkg::POS_W'(hsc16_pkg::HDR_LEN);
            end
         end else begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = b;
            rsp_idx_in   = pos_ff;
            rsp_last_in  = 1'b0;
            rsp_good_in  = 1'b0;
            if (frame_end) begin
               rsp_last_in = 1'b1;
               rsp_good_in = ({crc_hi_ff, b} == crc_ff);
               matched_in  = '0;
               pos_in      = '0;
               in_frame_in = 1'b0;
               crc_in      = hsc16_pkg::CRC_INIT;
               crc_hi_in   = '0;
            end else begin
               if ((pos_ext + 8'd2) == cfg.frame_len) begin
                  crc_hi_in = b;
               end else begin
                  crc_in = hsc16_pkg::crc_byte(crc_ff, b);
               end
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff   <= '0;
         pos_ff       <= '0;
         in_frame_ff  <= 1'b0;
         crc_ff       <= hsc16_pkg::CRC_INIT;
         crc_hi_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matched_ff   <= matched_in;
         pos_ff       <= pos_in;
         in_frame_ff  <= in_frame_in;
         crc_ff       <= crc_in;
         crc_hi_ff    <= crc_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_good_ff <= rsp_good_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_idx_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_good_ff;

   a_good_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("crc_good set on a byte that does not end the frame");

   a_index_past_header: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:8] >= hsc16_pkg::POS_W'(hsc16_pkg::HDR_LEN))
      else $error("emitted byte index lies inside the header");

   a_end_restarts_hunt: assert property (@(posedge clock) disable iff (reset)
      in_fire && in_frame_ff && frame_end |=> !in_frame_ff && matched_ff == '0
      && rsp_tvalid && rsp_tlast)
      else $error("frame end did not restart the header hunt");

   a_hunt_pos_clear: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> pos_ff == '0 && matched_ff < HDR_CNT)
      else $error("hunt state inconsistent");

endmodule

`default_nettype wire

// ===== test/header_sync_crc16_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// header_sync_crc16_deframer_tb: self-checking bench for the frame deframer
// Drives received bytes on req_*, and checks every frame byte on rsp_* against
// a scoreboard that tracks header hunt, frame position and CRC-16/Modbus.
// Directed frames cover length clamping, header restart and a length change
// mid-frame. Random frames, broken headers and noise then run under changing
// header and length settings, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module header_sync_crc16_deframer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [hsc16_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic [6:0] index;
      logic       last;
      logic       crc_good;
   } frame_out_type;

   class frame_byte_scoreboard_type;
      logic [7:0]    hdr [hsc16_pkg::HDR_LEN];
      logic [7:0]    len_reg;
      logic [2:0]    matched;
      logic [6:0]    pos;
      logic          in_frame;
      logic [15:0]   crc;
      logic [7:0]    crc_hi;
      frame_out_type expected_bytes [$];
      int            mismatches;
      int            results_seen;

      function new();
         for (int k = 0; k < hsc16_pkg::HDR_LEN; k++) begin
            hdr[k] = 8'h00;
         end
         len_reg      = hsc16_pkg::FRAME_LEN_RST;
         mismatches   = 0;
         results_seen = 0;
         restart();
      endfunction

      function void restart();
         matched  = 3'd0;
         pos      = 7'd0;
         in_frame = 1'b0;
         crc      = hsc16_pkg::CRC_INIT;
         crc_hi   = 8'h00;
      endfunction

      function void set_reg(logic [hsc16_pkg::CSR_IDX_W-1:0] idx, logic [7:0] v);
         if (idx < hsc16_pkg::REG_FRAME_LEN) begin
            hdr[idx] = v;
         end else if (idx == hsc16_pkg::REG_FRAME_LEN) begin
            len_reg = v;
         end
      endfunction

      function int eff_len();
         int n;
         n = len_reg;
         if (n < hsc16_pkg::MIN_FRAME_LEN) n = hsc16_pkg::MIN_FRAME_LEN;
         if (n > hsc16_pkg::MAX_FRAME_LEN) n = hsc16_pkg::MAX_FRAME_LEN;
         return n;
      endfunction

      function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
         logic [15:0] r;
         r = c ^ {8'h00, b};
         repeat (8) r = (r >> 1) ^ (r[0] ? hsc16_pkg::CRC_POLY : 16'h0000);
         return r;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void note_rx_byte(logic [7:0] b);
         frame_out_type item;
         int            n;
         int            p;
         n = eff_len();
         if (!in_frame) begin
            if (matched < hsc16_pkg::HDR_LEN && b == hdr[matched]) begin
               crc     = crc_update(crc, b);
               matched = 3'(matched + 1);
            end else if (b == hdr[0]) begin
               crc     = crc_update(hsc16_pkg::CRC_INIT, b);
               matched = 3'd1;
            end else begin
               crc     = hsc16_pkg::CRC_INIT;
               matched = 3'd0;
            end
            if (matched >= hsc16_pkg::HDR_LEN) begin
               in_frame = 1'b1;
               pos      = 7'(hsc16_pkg::HDR_LEN);
            end
            return;
         end
         p             = pos;
         item.data     = b;
         item.index    = p[6:0];
         item.last     = 1'b0;
         item.crc_good = 1'b0;
         if (p + 1 >= n) begin
            item.last     = 1'b1;
            item.crc_good = ({crc_hi, b} == crc);
            restart();
         end else begin
            if (p + 2 == n) begin
               crc_hi = b;
            end else begin
               crc = crc_update(crc, b);
            end
            pos = 7'(p + 1);
         end
         expected_bytes.push_back(item);
      endfunction

      function void check_frame_byte(logic [15:0] tdata, logic tlast, logic tuser);
         frame_out_type want;
         results_seen++;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected frame byte %h index %0d last %b crc_good %b",
                        tdata[7:0], tdata[14:8], tlast, tuser);
            end
            return;
         end
         want = expected_bytes.pop_front();
         if (tdata[7:0] !== want.data || tdata[14:8] !== want.index ||
             tlast !== want.last || tuser !== want.crc_good) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d exp byte %h index %0d last %b crc_good %b",
                        results_seen, want.data, want.index, want.last, want.crc_good);
               $display("       got byte %h index %0d last %b crc_good %b",
                        tdata[7:0], tdata[14:8], tlast, tuser);
            end
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   wire logic                       req_tready;
   logic [7:0]                      req_tdata  = 8'h00;
   wire logic                       rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   wire logic [15:0]                rsp_tdata;
   wire logic                       rsp_tlast;
   wire logic                       rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [hsc16_pkg::CSR_IDX_W-1:0] csr_index  = hsc16_pkg::REG_HDR0;
   logic [hsc16_pkg::BYTE_W-1:0]    csr_wdata  = 8'h00;

   frame_byte_scoreboard_type sb = new();

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   int items_sent    = 0;
   int send_idle_tbl [4] = '{0, 87, 0, 25};
   int stall_tbl [4]     = '{0, 0, 87, 25};

   header_sync_crc16_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_frame_byte(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_rx_byte(b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [hsc16_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_whole_frame(input bit corrupt);
      int          n;
      logic [15:0] c;
      logic [7:0]  b;
      n = sb.eff_len();
      c = hsc16_pkg::CRC_INIT;
      for (int k = 0; k < hsc16_pkg::HDR_LEN; k++) begin
         c = sb.crc_update(c, sb.hdr[k]);
         send_byte(sb.hdr[k]);
      end
      for (int k = 0; k < n - hsc16_pkg::HDR_LEN - 2; k++) begin
         b = 8'($urandom_range(255));
         c = sb.crc_update(c, b);
         send_byte(b);
      end
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(15));
      send_byte(c[15:8]);
      send_byte(c[7:0]);
   endtask

   task automatic send_broken_header();
      int         cut;
      logic [7:0] b;
      cut = $urandom_range(1, hsc16_pkg::HDR_LEN - 1);
      for (int k = 0; k < cut; k++) begin
         send_byte(sb.hdr[k]);
      end
      b = 8'($urandom_range(255));
      if (b == sb.hdr[cut]) b = ~b;
      send_byte(b);
   endtask

   task automatic configure_random(input int phase);
      int         pick;
      logic [7:0] v;
      for (int k = 0; k < hsc16_pkg::HDR_LEN; k++) begin
         pick = $urandom_range(7);
         v    = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
         write_reg(hsc16_pkg::reg_idx_type'(k), v);
      end
      pick = $urandom_range(31);
      case (pick)
         0: v = 8'd128;
         1: v = 8'd129;
         2: v = 8'd0;
         3: v = 8'd8;
         4: v = 8'd9;
         default: v = 8'($urandom_range(10, 24));
      endcase
      if (phase == 1) v = 8'd255;
      write_reg(hsc16_pkg::REG_FRAME_LEN, v);
   endtask

   initial begin
      logic [7:0] dir_hdr [hsc16_pkg::HDR_LEN];
      int         phase;
      int         frames;
      int         pick;

      dir_hdr = '{8'hA5, 8'h3C, 8'h00, 8'hFF, 8'h81, 8'h7E};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // broken header under reset settings
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h5A);
      send_byte(8'hFF);

      for (int k = 0; k < hsc16_pkg::HDR_LEN; k++) begin
         write_reg(hsc16_pkg::reg_idx_type'(k), dir_hdr[k]);
      end
      write_reg(hsc16_pkg::REG_FRAME_LEN, 8'd0);
      write_reg(REG_UNUSED, 8'h55);
      send_whole_frame(1'b0);
      send_whole_frame(1'b1);

      // restart on a byte that matches the first header byte
      send_byte(8'hA5);
      send_byte(8'h3C);
      send_byte(8'hA5);
      send_whole_frame(1'b0);

      // shrink the length mid-frame
      write_reg(hsc16_pkg::REG_FRAME_LEN, 8'd20);
      for (int k = 0; k < hsc16_pkg::HDR_LEN; k++) begin
         send_byte(sb.hdr[k]);
      end
      repeat (5) send_byte(8'($urandom_range(255)));
      write_reg(hsc16_pkg::REG_FRAME_LEN, 8'd8);
      send_byte(8'h00);
      send_whole_frame(1'b0);

      phase = 0;
      while (items_sent < 650) begin
         configure_random(phase);
         send_idle_pct = send_idle_tbl[phase % 4];
         stall_pct     = stall_tbl[phase % 4];
         if (phase == 0) hold_left = 300;
         frames = (sb.eff_len() > 40) ? 2 : 6;
         repeat (frames) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               send_whole_frame(1'b0);
            end else if (pick < 77) begin
               send_whole_frame(1'b1);
            end else if (pick < 89) begin
               send_broken_header();
            end else begin
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(7) == 0) drain();
         end
         phase++;
      end

      send_idle_pct = 0;
      drain();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
